/* sv/dcav_pkg.sv */
// ----------------------------------------------------------------------------
// dcav_pkg
// Types, codes and tables for the datagram check and ack verdict block.
// ----------------------------------------------------------------------------
package dcav_pkg;

  localparam int OFF_W = 10;
  localparam int SUM_W = 18;
  localparam int SEQ_W = 34;
  localparam int VERDICT_W = 3;
  localparam int MOD_BASE = 6;

  localparam logic [OFF_W-1:0] TYPE_POS = 10'd0;
  localparam logic [OFF_W-1:0] SEQ_FIRST = 10'd1;
  localparam logic [OFF_W-1:0] SEQ_LAST = 10'd10;
  localparam logic [OFF_W-1:0] CKSUM_POS = 10'd11;

  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_N = 8'h4e;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [VERDICT_W-1:0] VERDICT_DATA_GOOD = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DATA_BAD = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_ACK_SEEN = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_NACK_SEEN = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_OTHER = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [SEQ_W-1:0]     seq_number;
    logic                 seq_missing;
  } out_t;

  // one finished datagram handed from front to back
  typedef struct packed {
    logic [7:0]       type_byte;
    logic [7:0]       checksum_byte;
    logic             sum_neg;
    logic [2:0]       sum_res;
    logic [SEQ_W-1:0] seq_value;
    logic             any_digit;
  } rec_t;

  typedef logic [255:0][2:0] res_tab_t;

  // residue in 0..5 of each byte taken as a signed char
  function automatic res_tab_t build_res_tab();
    res_tab_t t;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i < 128) ? i : i - 256;
      t[i] = 3'(((v % MOD_BASE) + MOD_BASE) % MOD_BASE);
    end
    return t;
  endfunction

  localparam res_tab_t RES_TAB = build_res_tab();

endpackage

/* sv/datagram_check_ack_verdict.sv */
// ----------------------------------------------------------------------------
// datagram_check_ack_verdict
// Checks a received datagram byte stream and gives one ack verdict per datagram.
//
//   channel  signals                        beat
//   rx       rx_valid rx_ready rx_data      one datagram byte, last_byte on final
//   res      res_valid res_ready res_data   verdict, sequence number, no-digit
//
// one byte a cycle while rx_ready; a verdict goes via queue and result register
// the front updates its accumulators in the cycle a byte arrives
// a two-entry queue holds finished datagrams while the result side stalls
// rx_ready drops only while that queue is full
// synchronous reset clears all accumulators and empties queue and output
// ----------------------------------------------------------------------------
module datagram_check_ack_verdict #(
  parameter int MAX_LEN = 777
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_ready,
  input  dcav_pkg::in_t  rx_data,
  output logic           res_valid,
  input  logic           res_ready,
  output dcav_pkg::out_t res_data
);

  logic           f_valid;
  logic           f_ready;
  dcav_pkg::rec_t f_data;
  logic           q_valid;
  logic           q_ready;
  dcav_pkg::rec_t q_data;

  dcav_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_data(rx_data),
    .rec_valid(f_valid),
    .rec_ready(f_ready),
    .rec_data(f_data)
  );

  dcav_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data(f_data),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data(q_data)
  );

  dcav_back u_back (
    .clk(clk),
    .rst(rst),
    .rec_valid(q_valid),
    .rec_ready(q_ready),
    .rec_data(q_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

endmodule

/* sv/dcav_front.sv */
// ----------------------------------------------------------------------------
// dcav_front
// Byte accumulator: type, checksum, sequence digits and sum residue.
// ----------------------------------------------------------------------------
module dcav_front #(
  parameter int MAX_LEN = 777
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_ready,
  input  dcav_pkg::in_t  rx_data,
  output logic           rec_valid,
  input  logic           rec_ready,
  output dcav_pkg::rec_t rec_data
);

  localparam logic [dcav_pkg::OFF_W-1:0] MAX_OFF = dcav_pkg::OFF_W'(MAX_LEN);

  logic [dcav_pkg::OFF_W-1:0] byte_offset, byte_offset_next;
  logic signed [dcav_pkg::SUM_W-1:0] running_sum, running_sum_next;
  logic [2:0] sum_res, sum_res_next;
  logic [7:0] type_byte, type_byte_next;
  logic [7:0] checksum_byte, checksum_byte_next;
  logic [dcav_pkg::SEQ_W-1:0] seq_value, seq_value_next;
  logic seq_stopped, seq_stopped_next;
  logic seq_any_digit, seq_any_digit_next;

  logic       take;
  logic       in_range;
  logic       is_digit;
  logic [3:0] res_sum;

  assign rx_ready = rec_ready;
  assign take = rx_valid && rx_ready;
  assign in_range = byte_offset < MAX_OFF;
  assign is_digit = (rx_data.rx_byte >= dcav_pkg::CHAR_0) && (rx_data.rx_byte <= dcav_pkg::CHAR_9);
  assign res_sum = {1'b0, sum_res} + {1'b0, dcav_pkg::RES_TAB[rx_data.rx_byte]};

  always_comb begin
    byte_offset_next = byte_offset;
    running_sum_next = running_sum;
    sum_res_next = sum_res;
    type_byte_next = type_byte;
    checksum_byte_next = checksum_byte;
    seq_value_next = seq_value;
    seq_stopped_next = seq_stopped;
    seq_any_digit_next = seq_any_digit;
    if (in_range) begin
      if (byte_offset == dcav_pkg::TYPE_POS) begin
        type_byte_next = rx_data.rx_byte;
      end
      if (byte_offset == dcav_pkg::CKSUM_POS) begin
        checksum_byte_next = rx_data.rx_byte;
      end else begin
        running_sum_next = running_sum +
          dcav_pkg::SUM_W'(signed'(rx_data.rx_byte));
        sum_res_next = (res_sum >= 4'(dcav_pkg::MOD_BASE)) ?
          3'(res_sum - 4'(dcav_pkg::MOD_BASE)) : res_sum[2:0];
      end
      if (byte_offset >= dcav_pkg::SEQ_FIRST && byte_offset <= dcav_pkg::SEQ_LAST &&
          !seq_stopped) begin
        if (is_digit) begin
          seq_value_next = (seq_value << 3) + (seq_value << 1) +
            dcav_pkg::SEQ_W'(rx_data.rx_byte - dcav_pkg::CHAR_0);
          seq_any_digit_next = 1'b1;
        end else begin
          seq_stopped_next = 1'b1;
        end
      end
      byte_offset_next = byte_offset + dcav_pkg::OFF_W'(1);
    end
  end

  assign rec_valid = take && rx_data.last_byte;
  assign rec_data.type_byte = type_byte_next;
  assign rec_data.checksum_byte = checksum_byte_next;
  assign rec_data.sum_neg = running_sum_next[dcav_pkg::SUM_W-1];
  assign rec_data.sum_res = sum_res_next;
  assign rec_data.seq_value = seq_value_next;
  assign rec_data.any_digit = seq_any_digit_next;

  always_ff @(posedge clk) begin
    if (rst || (take && rx_data.last_byte)) begin
      byte_offset <= '0;
      running_sum <= '0;
      sum_res <= '0;
      type_byte <= '0;
      checksum_byte <= '0;
      seq_value <= '0;
      seq_stopped <= 1'b0;
      seq_any_digit <= 1'b0;
    end else if (take) begin
      byte_offset <= byte_offset_next;
      running_sum <= running_sum_next;
      sum_res <= sum_res_next;
      type_byte <= type_byte_next;
      checksum_byte <= checksum_byte_next;
      seq_value <= seq_value_next;
      seq_stopped <= seq_stopped_next;
      seq_any_digit <= seq_any_digit_next;
    end
  end

endmodule

/* sv/dcav_queue.sv */
// ----------------------------------------------------------------------------
// dcav_queue
// Two-entry queue of finished datagram records between front and back.
// ----------------------------------------------------------------------------
module dcav_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dcav_pkg::rec_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output dcav_pkg::rec_t rd_data
);

  dcav_pkg::rec_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = slot[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/dcav_back.sv */
// ----------------------------------------------------------------------------
// dcav_back
// Verdict stage: checksum compare, type decode and registered result.
// ----------------------------------------------------------------------------
module dcav_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_valid,
  output logic           rec_ready,
  input  dcav_pkg::rec_t rec_data,
  output logic           res_valid,
  input  logic           res_ready,
  output dcav_pkg::out_t res_data
);

  logic signed [3:0] calc;
  logic signed [9:0] recv;
  logic [dcav_pkg::VERDICT_W-1:0] verdict;
  logic take;

  assign rec_ready = !res_valid || res_ready;
  assign take = rec_valid && rec_ready;

  // c remainder takes the sign of the sum
  assign calc = (rec_data.sum_neg && rec_data.sum_res != 3'd0) ?
    signed'({1'b0, rec_data.sum_res}) - 4'sd6 : signed'({1'b0, rec_data.sum_res});
  assign recv = 10'(signed'(rec_data.checksum_byte)) - 10'(dcav_pkg::CHAR_0);

  always_comb begin
    unique case (rec_data.type_byte)
      dcav_pkg::CHAR_D: verdict = (10'(calc) == recv) ?
        dcav_pkg::VERDICT_DATA_GOOD : dcav_pkg::VERDICT_DATA_BAD;
      dcav_pkg::CHAR_A: verdict = dcav_pkg::VERDICT_ACK_SEEN;
      dcav_pkg::CHAR_N: verdict = dcav_pkg::VERDICT_NACK_SEEN;
      default: verdict = dcav_pkg::VERDICT_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rec_ready) begin
      res_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data.verdict <= verdict;
      res_data.seq_number <= rec_data.seq_value;
      res_data.seq_missing <= !rec_data.any_digit;
    end
  end

endmodule

/* sv/dcav_checker.sv */
// ----------------------------------------------------------------------------
// dcav_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dcav_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input dcav_pkg::out_t res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result beat changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.verdict <= dcav_pkg::VERDICT_OTHER)
    else $error("verdict code out of range");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.seq_missing |-> res_data.seq_number == '0)
    else $error("sequence number set with no digit");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind datagram_check_ack_verdict dcav_checker u_dcav_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res_data(res_data)
);
